@@ hw/rtl/gmd_pkg.sv @@
package gmd_pkg;

   localparam int CoordWidth = 3;
   localparam int MapWidth   = 64;
   localparam int StackDepth = 64;
   localparam int AddrWidth  = 6;
   localparam int DepthWidth = 7;
   localparam int CellWidth  = 2 * CoordWidth;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_PATH    = 2'd0;
   localparam status_type STATUS_NOPATH  = 2'd1;
   localparam status_type STATUS_INVALID = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       step;
      logic       pop_load;
      logic       emit_init;
      logic       emit_read;
      logic       out_cell;
      logic       out_code;
      status_type code;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_ok;
      logic at_end;
      logic push;
      logic depth_one;
      logic out_last;
   } stat_type;

endpackage

@@ hw/rtl/gmd_req_if.sv @@
interface gmd_req_if import gmd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CoordWidth-1:0] start_row;
   logic [CoordWidth-1:0] start_col;
   logic [CoordWidth-1:0] end_row;
   logic [CoordWidth-1:0] end_col;

   modport source (output valid, start_row, start_col, end_row, end_col, input ready);
   modport sink   (input valid, start_row, start_col, end_row, end_col, output ready);
endinterface

@@ hw/rtl/gmd_rsp_if.sv @@
interface gmd_rsp_if import gmd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   status_type            status;
   logic [CoordWidth-1:0] cell_row;
   logic [CoordWidth-1:0] cell_col;
   logic                  last;

   modport source (output valid, status, cell_row, cell_col, last, input ready);
   modport sink   (input valid, status, cell_row, cell_col, last, output ready);
endinterface

@@ hw/rtl/gmd_datapath.sv @@
module gmd_datapath import gmd_pkg::*; #(
   parameter int GRID_SIZE = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [MapWidth-1:0]   csr_wdata,
   input  logic [CoordWidth-1:0] start_row,
   input  logic [CoordWidth-1:0] start_col,
   input  logic [CoordWidth-1:0] end_row,
   input  logic [CoordWidth-1:0] end_col,
   input  cmd_type               cmd,
   output stat_type              stat,
   output status_type            out_status,
   output logic [CoordWidth-1:0] out_row,
   output logic [CoordWidth-1:0] out_col,
   output logic                  out_last
);

   function automatic logic [AddrWidth-1:0] cell_idx(input logic [CoordWidth-1:0] r,
                                                     input logic [CoordWidth-1:0] c);
      cell_idx = AddrWidth'(int'(r) * GRID_SIZE + int'(c));
   endfunction

   logic [MapWidth-1:0]   open_map_ff;
   logic [MapWidth-1:0]   visited_ff;
   logic [CoordWidth-1:0] top_row_ff, top_col_ff;
   logic [CoordWidth-1:0] end_row_ff, end_col_ff;
   logic [DepthWidth-1:0] depth_ff;
   logic [AddrWidth-1:0]  emit_idx_ff;
   logic [CellWidth-1:0]  rd_data_ff;
   logic [CellWidth-1:0]  stack_mem [StackDepth];

   status_type            out_status_ff;
   logic [CoordWidth-1:0] out_row_ff, out_col_ff;
   logic                  out_last_ff;

   logic [MapWidth-1:0]   visited_clr;
   logic [CoordWidth-1:0] next_row, next_col;
   logic                  moved;
   logic                  in_range;
   logic                  emit_last;
   logic                  wr_en;
   logic [AddrWidth-1:0]  wr_addr;
   logic [CellWidth-1:0]  wr_data;
   logic [AddrWidth-1:0]  rd_addr;
   logic [CoordWidth:0]   row_up1, col_up1;
   logic [DepthWidth-1:0] depth_dn2;

   // request check
   always_comb begin
      in_range = ({1'b0, start_row} < (CoordWidth+1)'(GRID_SIZE)) &&
                 ({1'b0, start_col} < (CoordWidth+1)'(GRID_SIZE)) &&
                 ({1'b0, end_row}   < (CoordWidth+1)'(GRID_SIZE)) &&
                 ({1'b0, end_col}   < (CoordWidth+1)'(GRID_SIZE));
   end

   // neighbor pick in the order up, down, right, left
   always_comb begin
      visited_clr = visited_ff & ~(MapWidth'(1) << cell_idx(top_row_ff, top_col_ff));
      row_up1     = {1'b0, top_row_ff} + 1'b1;
      col_up1     = {1'b0, top_col_ff} + 1'b1;
      next_row    = top_row_ff;
      next_col    = top_col_ff;
      moved       = 1'b0;
      if (top_row_ff != '0 &&
          visited_clr[cell_idx(top_row_ff - 1'b1, top_col_ff)]) begin
         next_row = top_row_ff - 1'b1;
         moved    = 1'b1;
      end else if (row_up1 < (CoordWidth+1)'(GRID_SIZE) &&
                   visited_clr[cell_idx(row_up1[CoordWidth-1:0], top_col_ff)]) begin
         next_row = row_up1[CoordWidth-1:0];
         moved    = 1'b1;
      end else if (col_up1 < (CoordWidth+1)'(GRID_SIZE) &&
                   visited_clr[cell_idx(top_row_ff, col_up1[CoordWidth-1:0])]) begin
         next_col = col_up1[CoordWidth-1:0];
         moved    = 1'b1;
      end else if (top_col_ff != '0 &&
                   visited_clr[cell_idx(top_row_ff, top_col_ff - 1'b1)]) begin
         next_col = top_col_ff - 1'b1;
         moved    = 1'b1;
      end
   end

   always_comb begin
      stat.req_ok    = in_range &&
                       open_map_ff[cell_idx(start_row, start_col)] &&
                       open_map_ff[cell_idx(end_row, end_col)] &&
                       !((start_row == end_row) && (start_col == end_col));
      stat.at_end    = (top_row_ff == end_row_ff) && (top_col_ff == end_col_ff);
      stat.push      = moved && (depth_ff != DepthWidth'(StackDepth));
      stat.depth_one = (depth_ff == DepthWidth'(1));
      stat.out_last  = out_last_ff;
      emit_last      = (({1'b0, emit_idx_ff} + DepthWidth'(1)) == depth_ff);
      depth_dn2      = depth_ff - DepthWidth'(2);
      rd_addr        = cmd.emit_read ? emit_idx_ff : depth_dn2[AddrWidth-1:0];
      wr_en          = cmd.load || (cmd.step && stat.push);
      wr_addr        = cmd.load ? '0 : depth_ff[AddrWidth-1:0];
      wr_data        = cmd.load ? {start_row, start_col} : {next_row, next_col};
   end

   // stack memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_map_ff <= '0;
         visited_ff  <= '0;
         depth_ff    <= '0;
         emit_idx_ff <= '0;
      end else begin
         if (csr_we) begin
            open_map_ff <= csr_wdata;
         end
         if (cmd.load) begin
            visited_ff <= open_map_ff;
            depth_ff   <= DepthWidth'(1);
         end else if (cmd.step) begin
            visited_ff <= visited_clr;
            depth_ff   <= stat.push ? depth_ff + 1'b1 : depth_ff - 1'b1;
         end
         if (cmd.emit_init) begin
            emit_idx_ff <= '0;
         end else if (cmd.out_cell) begin
            emit_idx_ff <= emit_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         top_row_ff <= start_row;
         top_col_ff <= start_col;
         end_row_ff <= end_row;
         end_col_ff <= end_col;
      end else if (cmd.step && stat.push) begin
         top_row_ff <= next_row;
         top_col_ff <= next_col;
      end else if (cmd.pop_load) begin
         top_row_ff <= rd_data_ff[CellWidth-1:CoordWidth];
         top_col_ff <= rd_data_ff[CoordWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_last_ff <= 1'b0;
      end else if (cmd.out_cell) begin
         out_last_ff <= emit_last;
      end else if (cmd.out_code) begin
         out_last_ff <= 1'b1;
      end
      if (cmd.out_cell) begin
         out_status_ff <= STATUS_PATH;
         out_row_ff    <= rd_data_ff[CellWidth-1:CoordWidth];
         out_col_ff    <= rd_data_ff[CoordWidth-1:0];
      end else if (cmd.out_code) begin
         out_status_ff <= cmd.code;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
      end
   end

   assign out_status = out_status_ff;
   assign out_row    = out_row_ff;
   assign out_col    = out_col_ff;
   assign out_last   = out_last_ff;

   // the cell on top of the stack is always an open cell
   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> open_map_ff[cell_idx(top_row_ff, top_col_ff)])
      else $error("top of stack is a closed cell");

   // visited map only ever loses open cells
   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> ((visited_ff & ~open_map_ff) == '0))
      else $error("visited map holds a closed cell");

   // a push grows the stack by one
   assert property (@(posedge clock) disable iff (reset)
      (cmd.step && stat.push) |=> (depth_ff == $past(depth_ff) + 1'b1))
      else $error("stack depth did not grow on push");

endmodule

@@ hw/rtl/gmd_ctrl.sv @@
module gmd_ctrl import gmd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_POP,
      S_EMIT_RD,
      S_EMIT_LD,
      S_HOLD
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd       = '0;
      cmd.code  = STATUS_INVALID;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load     = stat.req_ok;
               cmd.out_code = !stat.req_ok;
            end
         end
         S_SEARCH: begin
            if (stat.at_end) begin
               cmd.emit_init = 1'b1;
            end else begin
               cmd.step = 1'b1;
               if (!stat.push && stat.depth_one) begin
                  cmd.out_code = 1'b1;
                  cmd.code     = STATUS_NOPATH;
               end
            end
         end
         S_POP:     cmd.pop_load  = 1'b1;
         S_EMIT_RD: cmd.emit_read = 1'b1;
         S_EMIT_LD: cmd.out_cell  = 1'b1;
         S_HOLD:    ;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (stat.req_ok) begin
                     state_ff <= S_SEARCH;
                  end else begin
                     state_ff     <= S_HOLD;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_SEARCH: begin
               if (stat.at_end) begin
                  state_ff <= S_EMIT_RD;
               end else if (!stat.push) begin
                  if (stat.depth_one) begin
                     state_ff     <= S_HOLD;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= S_POP;
                  end
               end
            end
            S_POP:     state_ff <= S_SEARCH;
            S_EMIT_RD: state_ff <= S_EMIT_LD;
            S_EMIT_LD: begin
               state_ff     <= S_HOLD;
               rsp_valid_ff <= 1'b1;
            end
            S_HOLD: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= stat.out_last ? S_IDLE : S_EMIT_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/grid_maze_dfs_path_finder.sv @@
// invalid request: answered in the cycle after it is accepted
// search: a push stays in S_SEARCH, a pop also passes S_POP (registered stack read)
// path output: per path cell S_EMIT_RD, S_EMIT_LD, then S_HOLD until rsp_ready
// throughput: one request at a time, next request taken after the last result is taken
// reset: synchronous active-high reset clears the map, control and counters
// the path stack memory has no reset, every entry read is written first
module grid_maze_dfs_path_finder import gmd_pkg::*; #(
   parameter int GRID_SIZE = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [MapWidth-1:0] csr_wdata,
   gmd_req_if.sink             req_if,
   gmd_rsp_if.source           rsp_if
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: accept, search loop, path read-out
   gmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // open map, visited map, top cell, path stack and result register
   gmd_datapath #(
      .GRID_SIZE (GRID_SIZE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .start_row  (req_if.start_row),
      .start_col  (req_if.start_col),
      .end_row    (req_if.end_row),
      .end_col    (req_if.end_col),
      .cmd        (cmd),
      .stat       (stat),
      .out_status (rsp_if.status),
      .out_row    (rsp_if.cell_row),
      .out_col    (rsp_if.cell_col),
      .out_last   (rsp_if.last)
   );

endmodule
